// File: rtl/sls_pkg.sv
// Shared constants and types for the semi-local LCS seaweed combing block.
package sls_pkg;

  localparam int A_DEPTH   = 64;
  localparam int A_IDX_W   = $clog2(A_DEPTH);
  localparam int LEN_W     = $clog2(A_DEPTH + 1);
  localparam int SYM_W     = 8;
  localparam int COL_W     = 11;
  localparam int MAX_B_LEN = 1024;
  localparam int LCS_MAX   = (1 << LEN_W) - 1;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROC = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_A_LENGTH = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // seaweed value handed from one row cell to the next
  typedef struct packed {
    logic             tok;
    logic [COL_W-1:0] x;
  } link_t;

endpackage

// File: rtl/sls_cell.sv
// One row cell: holds an a symbol and its row value, combs the passing seaweed.
module sls_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_en,
  input  logic [sls_pkg::SYM_W-1:0] load_sym,
  input  logic                      clear,
  input  logic                      active,
  input  logic [sls_pkg::SYM_W-1:0] b_sym,
  input  sls_pkg::link_t            link_in,
  output sls_pkg::link_t            link_out
);
  import sls_pkg::*;

  logic [SYM_W-1:0] a_sym;
  logic [COL_W-1:0] row;
  logic             swap;

  // match always swaps; mismatch keeps the minimum in the row
  assign swap = (a_sym == b_sym) || (row > link_in.x);

  always_ff @(posedge clk) begin
    if (load_en) begin
      a_sym <= load_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= '0;
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_in.tok && active;
      if (clear) begin
        row <= '0;
      end else if (link_in.tok && active && swap) begin
        row <= link_in.x;
      end
      if (link_in.tok && active) begin
        link_out.x <= swap ? row : link_in.x;
      end
    end
  end

endmodule

// File: rtl/semi_local_lcs_seaweed.sv
// Top level: APB register, input/output words and the row of seaweed cells.
//
// Usage. Program a_length (byte address 0) over the APB port while idle.
// Load string a with func = 0 words, one symbol per word at position; each
// load word is written into its cell and gives no result. Then stream string b
// with func = 1 words, first set on its opening symbol to clear the rows and the
// LCS count and restart the column count. Each process word yields one result
// word: column r, the bottom seaweed value h[n][r] and the LCS of a with
// b[0,r). A process word without first after 1024 columns is dropped.
// Timing: the seaweed token walks the row of cells one cell per cycle, and
// once it has passed row n (n = a_length, capped at 64) the result goes to
// the output register and the block returns to idle; it takes no word while
// a token is in the row. The output register holds a finished result while
// the receiver stalls; the block still takes the next word, but a later
// result waits in the last cell until the output register frees up.
// Reset clears a_length, the row values, the counters and out_valid;
// the a symbols are undefined until loaded.
module semi_local_lcs_seaweed (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sls_pkg::ADDR_W-1:0] paddr,
  input  logic [sls_pkg::DATA_W-1:0] pwdata,
  output logic [sls_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [sls_pkg::A_IDX_W-1:0] position,
  input  logic [sls_pkg::SYM_W-1:0]  symbol,
  input  logic                       first,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sls_pkg::COL_W-1:0]  column,
  output logic [sls_pkg::COL_W-1:0]  seaweed_start,
  output logic [sls_pkg::LEN_W-1:0]  prefix_lcs
);
  import sls_pkg::*;

  state_t           state, state_next;
  logic [LEN_W-1:0] a_length;
  logic [LEN_W-1:0] n_clamped;
  logic [LEN_W-1:0] n_reg;
  logic [LEN_W-1:0] step;
  logic [COL_W-1:0] col_cnt;
  logic [COL_W-1:0] col_next;
  logic [LEN_W-1:0] lcs_cnt;
  logic [LEN_W-1:0] lcs_next;
  logic [SYM_W-1:0] b_sym;
  logic             tok0;
  logic             accept;
  logic             do_load;
  logic             do_proc;
  logic             done;
  logic             cfg_wr;
  logic [COL_W-1:0] x_final;
  logic [A_DEPTH-1:0] tok_vec;
  link_t            links [0:A_DEPTH];

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_A_LENGTH);
  assign prdata = (paddr[2] == REG_A_LENGTH) ? DATA_W'(a_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_length <= '0;
    end else if (cfg_wr) begin
      a_length <= pwdata[LEN_W-1:0];
    end
  end

  assign n_clamped = (a_length > LEN_W'(A_DEPTH)) ? LEN_W'(A_DEPTH) : a_length;

  assign accept   = in_valid && in_ready;
  assign do_load  = accept && (func == FUNC_LOAD);
  assign do_proc  = accept && (func == FUNC_PROC) &&
                    (first || (col_cnt < COL_W'(MAX_B_LEN)));
  assign col_next = first ? COL_W'(1) : col_cnt + COL_W'(1);

  // value leaving row n; with n = 0 it is the entry value r
  assign x_final  = links[n_reg].x;
  assign lcs_next = ((x_final == '0) && (lcs_cnt != LEN_W'(LCS_MAX))) ?
                    lcs_cnt + LEN_W'(1) : lcs_cnt;

  // state machine
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (do_proc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((step == n_reg) && (!out_valid || out_ready)) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      lcs_cnt   <= '0;
      tok0      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      tok0 <= do_proc;
      if (do_proc) begin
        col_cnt <= col_next;
        step    <= '0;
        if (first) begin
          lcs_cnt <= '0;
        end
      end else if ((state == ST_RUN) && (step != n_reg)) begin
        step <= step + LEN_W'(1);
      end
      if (done) begin
        lcs_cnt   <= lcs_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_proc) begin
      b_sym      <= symbol;
      n_reg      <= n_clamped;
    end
    if (done) begin
      column        <= col_cnt;
      seaweed_start <= x_final;
      prefix_lcs    <= lcs_next;
    end
  end

  // the column count holds the entry value r while its token walks the row
  assign links[0] = '{tok: tok0, x: col_cnt};

  // row of cells
  for (genvar k = 0; k < A_DEPTH; k++) begin : g_cell
    sls_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load_en  (do_load && (position == A_IDX_W'(k))),
      .load_sym (symbol),
      .clear    (do_proc && first),
      .active   (LEN_W'(k) < n_reg),
      .b_sym    (b_sym),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );
    assign tok_vec[k] = links[k+1].tok;
  end

  // at most one seaweed token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok0, tok_vec}))
    else $error("more than one token in the cell row");

  // no token remains once the block is idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (tok_vec == '0))
    else $error("token left in the row while idle");

  // step never runs past the row count
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= n_reg))
    else $error("step counter past row count");

  // a result is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(seaweed_start)))
    else $error("pending result overwritten");

  // LCS never exceeds the number of columns seen
  a_lcs_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (COL_W'(prefix_lcs) <= column))
    else $error("prefix LCS above column");

endmodule
